// ===== design/wfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_pkg: shared types and constants
// Widths, character codes, status codes and the front-to-back request type.
// ----------------------------------------------------------------------------
package wfc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int WORD_CHARS    = 8;
    localparam int COUNT_BITS    = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int FILL_W        = $clog2(WORD_CHARS + 2);
    localparam int TEXT_W        = 8 * WORD_CHARS;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SPACE_CODE = 8'h20;
    localparam logic [7:0] APOS_CODE  = 8'h27;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOOLONG = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Request from tokenizer to table: a finished word or an end of sentence.
    typedef struct packed {
        logic              is_end;
        logic              too_long;   // word overflowed the buffer
        logic              empty;      // end with no byte before it
        logic [TEXT_W-1:0] text;
        logic [FILL_W-1:0] len;
    } wfc_req_t;

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

endpackage

// ===== design/wfc_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_tokenizer: character front end
// Lowercases, resolves apostrophes with one byte of lookahead and emits
// finished words and end markers as requests.
// ----------------------------------------------------------------------------
module wfc_tokenizer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [7:0]        char_code,
    output logic              req_valid,
    input  logic              req_ready,
    output wfc_pkg::wfc_req_t req
);
    import wfc_pkg::*;

    logic [TEXT_W-1:0] buf_reg, buf_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        prev_reg;
    logic              start_reg, pend_reg, pend_next;
    logic              err_reg, err_next;
    logic              acc;
    logic              emit;
    wfc_req_t          req_w;

    // Word buffer, lookahead and local error tracking.
    always_comb
    begin
        logic fin;
        logic [7:0] ch;
        logic app;
        buf_next  = buf_reg;
        fill_next = fill_reg;
        pend_next = pend_reg;
        err_next  = err_reg;
        emit      = 1'b0;
        fin       = 1'b0;
        app       = 1'b0;
        ch        = to_lower(char_code);
        req_w          = '0;
        req_w.text     = buf_reg;
        req_w.len      = fill_reg;
        req_w.too_long = (fill_reg > FILL_W'(WORD_CHARS));
        if (kind)
        begin
            // the end request carries the open word; a pending apostrophe drops
            req_w.is_end = 1'b1;
            req_w.empty  = start_reg;
            emit         = 1'b1;
            buf_next = '0; fill_next = '0; pend_next = 1'b0; err_next = 1'b0;
        end
        else if (!err_reg)
        begin
            if (pend_reg)
            begin
                pend_next = 1'b0;
                if (char_code == SPACE_CODE) fin = 1'b1;
                else
                begin
                    // append apostrophe; a following letter is also appended
                    if (fill_reg < FILL_W'(WORD_CHARS))
                        buf_next[8*fill_reg[$clog2(WORD_CHARS+1)-1:0] +: 8] = APOS_CODE;
                    if (fill_reg <= FILL_W'(WORD_CHARS)) fill_next = fill_reg + 1'b1;
                end
            end
            if (!fin)
            begin
                if (is_word_char(char_code)) app = 1'b1;
                else if (char_code == APOS_CODE && !(start_reg || prev_reg == SPACE_CODE))
                    pend_next = 1'b1;
                else fin = 1'b1;
            end
            if (app)
            begin
                if (fill_next < FILL_W'(WORD_CHARS))
                    buf_next[8*fill_next[$clog2(WORD_CHARS+1)-1:0] +: 8] = ch;
                if (fill_next <= FILL_W'(WORD_CHARS)) fill_next = fill_next + 1'b1;
            end
            if (fin)
            begin
                // finish current word; a pending-space case sees the word as is
                req_w.text     = buf_next;
                req_w.len      = fill_next;
                req_w.too_long = (fill_next > FILL_W'(WORD_CHARS));
                emit           = (fill_next != '0);
                if (req_w.too_long) err_next = 1'b1;
                buf_next  = '0;
                fill_next = '0;
            end
        end
    end

    // A separator after a pending-space finish must not re-emit; the byte
    // that closed via the lookahead is a space, which is itself a separator
    // with an empty word, so a single emit per byte suffices.
    assign in_ready  = !req_valid || req_ready;
    assign acc       = in_valid && in_ready;

    // Hold one request at the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            start_reg <= 1'b1;
            pend_reg  <= 1'b0;
            err_reg   <= 1'b0;
            fill_reg  <= '0;
            buf_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (req_valid && req_ready && !(acc && emit)) req_valid <= 1'b0;
            if (acc)
            begin
                if (emit)
                begin
                    req_valid <= 1'b1;
                    req       <= req_w;
                end
                buf_reg   <= buf_next;
                fill_reg  <= fill_next;
                pend_reg  <= pend_next;
                err_reg   <= err_next;
                prev_reg  <= kind ? 8'h00 : char_code;
                start_reg <= kind;
            end
        end
    end

endmodule

// ===== design/wfc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_queue: request queue
// Small FIFO between tokenizer and table engine.
// ----------------------------------------------------------------------------
module wfc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  wfc_pkg::wfc_req_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output wfc_pkg::wfc_req_t rd_data
);
    import wfc_pkg::*;

    wfc_req_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              wr, rd;

    assign wr_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    // Store requests.
    always_ff @(posedge clk)
    begin
        if (wr) mem[wp_reg] <= wr_data;
    end

    // Advance pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + QCNT_W'(wr) - QCNT_W'(rd);
        end
    end

endmodule

// ===== design/wfc_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_table: word table engine
// Searches the table one entry a cycle, counts or inserts, and reports the
// table on an end request.
// ----------------------------------------------------------------------------
module wfc_table (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  wfc_pkg::wfc_req_t      req,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic                   entry_valid,
    output logic [3:0]             entry_index,
    output logic [63:0]            word_text,
    output logic [3:0]             word_len,
    output logic [15:0]            occurrences,
    output logic                   last
);
    import wfc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_REPORT = 4'b0100,
        S_WAIT   = 4'b1000
    } state_t;

    logic [TEXT_W-1:0]     t_text [TABLE_ENTRIES];
    logic [FILL_W-1:0]     t_len  [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] t_occ  [TABLE_ENTRIES];

    state_t            state_reg;
    logic [USED_W-1:0] used_reg, pos_reg;
    logic [1:0]        err_reg;
    wfc_req_t          cur_reg;
    logic              hit;
    logic [IDX_W-1:0]  pidx;
    logic              out_free;

    assign pidx       = pos_reg[IDX_W-1:0];
    assign hit        = (t_len[pidx] == cur_reg.len) && (t_text[pidx] == cur_reg.text);
    assign req_ready  = (state_reg == S_IDLE);
    assign out_free   = !out_valid || out_ready;

    // Sequence search, insert and report.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            pos_reg   <= '0;
            err_reg   <= ST_OK;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready && state_reg != S_REPORT) out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        cur_reg <= req;
                        pos_reg <= '0;
                        if (req.is_end)
                        begin
                            // finish the word that the end request carries
                            if (err_reg != ST_OK || req.empty || req.len == '0)
                                state_reg <= S_REPORT;
                            else if (req.too_long)
                            begin
                                err_reg   <= ST_TOOLONG;
                                state_reg <= S_REPORT;
                            end
                            else state_reg <= S_SEARCH;
                        end
                        else if (err_reg != ST_OK) state_reg <= S_IDLE;
                        else if (req.too_long) err_reg <= ST_TOOLONG;
                        else state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (pos_reg == used_reg)
                    begin
                        if (used_reg == USED_W'(TABLE_ENTRIES)) err_reg <= ST_FULL;
                        else
                        begin
                            t_text[pidx] <= cur_reg.text;
                            t_len[pidx]  <= cur_reg.len;
                            t_occ[pidx]  <= COUNT_BITS'(1);
                            used_reg     <= used_reg + 1'b1;
                        end
                        pos_reg   <= '0;
                        state_reg <= cur_reg.is_end ? S_REPORT : S_IDLE;
                    end
                    else if (hit)
                    begin
                        if (t_occ[pidx] != '1) t_occ[pidx] <= t_occ[pidx] + 1'b1;
                        pos_reg   <= '0;
                        state_reg <= cur_reg.is_end ? S_REPORT : S_IDLE;
                    end
                    else pos_reg <= pos_reg + 1'b1;
                end
                S_REPORT:
                begin
                    if (out_free)
                    begin
                        out_valid   <= 1'b1;
                        status      <= ST_OK;
                        entry_valid <= 1'b0;
                        entry_index <= '0;
                        word_text   <= '0;
                        word_len    <= '0;
                        occurrences <= '0;
                        last        <= 1'b1;
                        if (cur_reg.empty) status <= ST_TOOLONG;
                        else if (err_reg != ST_OK) status <= err_reg;
                        else if (used_reg != '0)
                        begin
                            entry_valid <= 1'b1;
                            entry_index <= 4'(pidx);
                            word_text   <= 64'(t_text[pidx]);
                            word_len    <= 4'(t_len[pidx]);
                            occurrences <= 16'(t_occ[pidx]);
                            last        <= (pos_reg + 1'b1 == used_reg);
                        end
                        if (cur_reg.empty || err_reg != ST_OK || used_reg == '0 ||
                            pos_reg + 1'b1 == used_reg)
                            state_reg <= S_WAIT;
                        else pos_reg <= pos_reg + 1'b1;
                    end
                end
                S_WAIT:
                begin
                    used_reg  <= '0;
                    err_reg   <= ST_OK;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/word_frequency_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_frequency_counter: per-sentence word count
// Counts distinct words of a sentence and reports them in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): kind and char_code; a sentence is
//   its bytes followed by one end request (kind 1).
//   Output channel (out_valid/out_ready): one result per table entry in
//   insertion order, or one status result; last marks the final one.
//   The tokenizer takes a byte whenever its held request is free or taken.
//   Each finished word is queued and then searched one table entry per
//   cycle; the four-deep queue absorbs this behind short bytes. The end
//   request also carries the last open word, which is searched first. The
//   report gives one result a cycle while the receiver takes them, from
//   the report state entered once the end request leaves the queue (after
//   that final search when there is one); a wait state then clears the engine.
//   Reset empties the table and the queue and clears the tokenizer state;
//   the held request's data is not reset. When the receiver stalls, the held
//   result waits; the engine stops, the queue fills and in_ready falls.
// ----------------------------------------------------------------------------
module word_frequency_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        entry_valid,
    output logic [3:0]  entry_index,
    output logic [63:0] word_text,
    output logic [3:0]  word_len,
    output logic [15:0] occurrences,
    output logic        last
);
    import wfc_pkg::*;

    wfc_req_t tok_req, q_req;
    logic     tok_valid, tok_ready, q_valid, q_ready;

    wfc_tokenizer u_tok (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .char_code(char_code), .req_valid(tok_valid),
        .req_ready(tok_ready), .req(tok_req)
    );

    wfc_queue u_q (
        .clk(clk), .rst_n(rst_n), .wr_valid(tok_valid), .wr_ready(tok_ready),
        .wr_data(tok_req), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
    );

    wfc_table u_tab (
        .clk(clk), .rst_n(rst_n), .req_valid(q_valid), .req_ready(q_ready),
        .req(q_req), .out_valid(out_valid),
        .out_ready(out_ready), .status(status), .entry_valid(entry_valid),
        .entry_index(entry_index), .word_text(word_text),
        .word_len(word_len), .occurrences(occurrences), .last(last)
    );

    // Status-only results carry no entry.
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_valid |-> last && occurrences == '0)
        else $error("status result carries entry data");

    // Error results never carry an entry.
    a_err_noentry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !entry_valid)
        else $error("error result with entry");

    // Reported entries have a nonzero count and length.
    a_entry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_valid |-> occurrences != '0 && word_len != '0)
        else $error("empty entry reported");

endmodule
